// ----- sv/i2cm_pkg.sv -----
`timescale 1ns / 1ps

package i2cm_pkg;

	// Command codes carried with each tick.
	localparam logic [1:0] CMD_TICK   = 2'd0;
	localparam logic [1:0] CMD_WRITE  = 2'd1;
	localparam logic [1:0] CMD_READ   = 2'd2;
	localparam logic [1:0] CMD_SUPPLY = 2'd3;

	// Completion status codes.
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_LOST = 2'd1;
	localparam logic [1:0] ST_NACK = 2'd2;

	// Reset value of the half period register.
	localparam logic [15:0] HALF_PERIOD_RESET = 16'd5;

	// Sequencer phases.
	typedef enum logic [3:0] {
		PH_IDLE     = 4'd0,
		PH_START_HI = 4'd1,
		PH_START_LO = 4'd2,
		PH_TX_LO    = 4'd3,
		PH_TX_HI    = 4'd4,
		PH_ACK_LO   = 4'd5,
		PH_ACK_HI   = 4'd6,
		PH_WAIT     = 4'd7,
		PH_RX_LO    = 4'd8,
		PH_RX_HI    = 4'd9,
		PH_MACK_LO  = 4'd10,
		PH_MACK_HI  = 4'd11,
		PH_STOP_LO  = 4'd12,
		PH_STOP_HI  = 4'd13
	} phase_t;

	// One input tick.
	typedef struct packed {
		logic [1:0] command;
		logic [7:0] addr_byte;
		logic [7:0] tx_byte;
		logic       sda_in;
		logic       bus_busy;
	} tick_t;

	// One result item.
	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       need_byte;
		logic       rx_valid;
		logic [7:0] rx_byte;
		logic       rx_last;
		logic       done_res;
		logic [1:0] status;
		logic       active;
	} result_t;

endpackage

// ----- sv/i2cm_seq.sv -----
`timescale 1ns / 1ps

module i2cm_seq
	import i2cm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  tick_t       tick,
	input  logic [15:0] half_period,
	output result_t     result
);

	phase_t      phase_q, phase_d;
	logic [15:0] tick_count_q, tick_count_d;
	logic [3:0]  bit_count_q, bit_count_d;
	logic [7:0]  shift_byte_q, shift_byte_d;
	logic [7:0]  bytes_left_q, bytes_left_d;
	logic        read_mode_q, read_mode_d;
	logic        length_pending_q, length_pending_d;
	logic        scl_q, scl_d;
	logic        sda_q, sda_d;

	logic [15:0] hp_eff;
	logic [15:0] tc_inc;
	logic [15:0] tc_next;
	logic        elapsed;
	logic [3:0]  bit_inc;
	logic [7:0]  shift_rx;
	logic [7:0]  bytes_rx;
	logic        rx_valid;
	logic        rx_last;
	logic        done;
	logic [1:0]  status;

	// Half bit timer: a zero period counts as one tick.
	always_comb begin
		hp_eff  = (half_period == 16'd0) ? 16'd1 : half_period;
		tc_inc  = tick_count_q + 16'd1;
		elapsed = (tc_inc >= hp_eff);
		tc_next = elapsed ? 16'd0 : tc_inc;
		bit_inc = bit_count_q + 4'd1;
		shift_rx = {shift_byte_q[6:0], tick.sda_in};
		if (length_pending_q) begin
			bytes_rx = shift_rx;
		end else if (bytes_left_q != 8'd0) begin
			bytes_rx = bytes_left_q - 8'd1;
		end else begin
			bytes_rx = bytes_left_q;
		end
	end

	// Next state of the bus sequencer for one tick.
	always_comb begin
		phase_d          = phase_q;
		tick_count_d     = tick_count_q;
		bit_count_d      = bit_count_q;
		shift_byte_d     = shift_byte_q;
		bytes_left_d     = bytes_left_q;
		read_mode_d      = read_mode_q;
		length_pending_d = length_pending_q;
		scl_d            = scl_q;
		sda_d            = sda_q;
		rx_valid         = 1'b0;
		rx_last          = 1'b0;
		done             = 1'b0;
		status           = ST_OK;
		unique case (phase_q)
			PH_IDLE: begin
				if (tick.command == CMD_WRITE || tick.command == CMD_READ) begin
					if (tick.bus_busy) begin
						done   = 1'b1;
						status = ST_LOST;
					end else begin
						read_mode_d      = (tick.command == CMD_READ);
						shift_byte_d     = tick.addr_byte;
						bit_count_d      = 4'd0;
						bytes_left_d     = 8'd0;
						length_pending_d = 1'b1;
						tick_count_d     = 16'd0;
						scl_d            = 1'b1;
						sda_d            = 1'b1;
						phase_d          = PH_START_HI;
					end
				end
			end
			PH_START_HI: begin
				tick_count_d = tc_next;
				if (elapsed) begin
					sda_d   = 1'b0;
					phase_d = PH_START_LO;
				end
			end
			PH_START_LO: begin
				tick_count_d = tc_next;
				if (elapsed) begin
					bit_count_d = 4'd0;
					phase_d     = PH_TX_LO;
					scl_d       = 1'b0;
					sda_d       = shift_byte_q[7];
				end
			end
			PH_TX_LO, PH_ACK_LO, PH_RX_LO, PH_MACK_LO, PH_STOP_LO: begin
				tick_count_d = tc_next;
				if (elapsed) begin
					scl_d = 1'b1;
					case (phase_q)
						PH_TX_LO:   phase_d = PH_TX_HI;
						PH_ACK_LO:  phase_d = PH_ACK_HI;
						PH_RX_LO:   phase_d = PH_RX_HI;
						PH_MACK_LO: phase_d = PH_MACK_HI;
						default:    phase_d = PH_STOP_HI;
					endcase
				end
			end
			PH_TX_HI: begin
				tick_count_d = tc_next;
				if (elapsed) begin
					if (sda_q && !tick.sda_in) begin
						// Another master pulled SDA low: release both lines, no stop.
						phase_d = PH_IDLE;
						scl_d   = 1'b1;
						sda_d   = 1'b1;
						done    = 1'b1;
						status  = ST_LOST;
					end else begin
						shift_byte_d = {shift_byte_q[6:0], 1'b0};
						bit_count_d  = bit_inc;
						scl_d        = 1'b0;
						if (bit_inc >= 4'd8) begin
							phase_d = PH_ACK_LO;
							sda_d   = 1'b1;
						end else begin
							phase_d = PH_TX_LO;
							sda_d   = shift_byte_q[6];
						end
					end
				end
			end
			PH_ACK_HI: begin
				tick_count_d = tc_next;
				if (elapsed) begin
					if (tick.sda_in) begin
						phase_d      = PH_STOP_LO;
						tick_count_d = 16'd0;
						scl_d        = 1'b0;
						sda_d        = 1'b0;
						bit_count_d  = {2'b00, ST_NACK};
					end else if (read_mode_q) begin
						phase_d      = PH_RX_LO;
						bit_count_d  = 4'd0;
						shift_byte_d = 8'd0;
						scl_d        = 1'b0;
						sda_d        = 1'b1;
					end else if (length_pending_q || bytes_left_q != 8'd0) begin
						phase_d = PH_WAIT;
						scl_d   = 1'b0;
						sda_d   = 1'b1;
					end else begin
						phase_d      = PH_STOP_LO;
						tick_count_d = 16'd0;
						scl_d        = 1'b0;
						sda_d        = 1'b0;
						bit_count_d  = {2'b00, ST_OK};
					end
				end
			end
			PH_WAIT: begin
				if (tick.command == CMD_SUPPLY) begin
					shift_byte_d = tick.tx_byte;
					if (length_pending_q) begin
						bytes_left_d     = tick.tx_byte;
						length_pending_d = 1'b0;
					end else if (bytes_left_q != 8'd0) begin
						bytes_left_d = bytes_left_q - 8'd1;
					end
					bit_count_d  = 4'd0;
					tick_count_d = 16'd0;
					phase_d      = PH_TX_LO;
					scl_d        = 1'b0;
					sda_d        = tick.tx_byte[7];
				end
			end
			PH_RX_HI: begin
				tick_count_d = tc_next;
				if (elapsed) begin
					shift_byte_d = shift_rx;
					bit_count_d  = bit_inc;
					scl_d        = 1'b0;
					if (bit_inc >= 4'd8) begin
						// Byte complete: the length byte loads the count; later bytes count it down.
						bytes_left_d     = bytes_rx;
						length_pending_d = 1'b0;
						rx_valid         = 1'b1;
						rx_last          = (bytes_rx == 8'd0);
						phase_d          = PH_MACK_LO;
						sda_d            = (bytes_rx == 8'd0);
					end else begin
						phase_d = PH_RX_LO;
					end
				end
			end
			PH_MACK_HI: begin
				tick_count_d = tc_next;
				if (elapsed) begin
					if (bytes_left_q == 8'd0) begin
						phase_d      = PH_STOP_LO;
						tick_count_d = 16'd0;
						scl_d        = 1'b0;
						sda_d        = 1'b0;
						bit_count_d  = {2'b00, ST_OK};
					end else begin
						phase_d      = PH_RX_LO;
						bit_count_d  = 4'd0;
						shift_byte_d = 8'd0;
						scl_d        = 1'b0;
						sda_d        = 1'b1;
					end
				end
			end
			PH_STOP_HI: begin
				tick_count_d = tc_next;
				if (elapsed) begin
					sda_d   = 1'b1;
					phase_d = PH_IDLE;
					done    = 1'b1;
					status  = bit_count_q[1:0];
				end
			end
			default: begin
				phase_d = PH_IDLE;
				scl_d   = 1'b1;
				sda_d   = 1'b1;
			end
		endcase
	end

	// Result item for this tick, taken from the state after the tick.
	always_comb begin
		result.scl_out   = scl_d;
		result.sda_out   = sda_d;
		result.need_byte = (phase_d == PH_WAIT);
		result.rx_valid  = rx_valid;
		result.rx_byte   = rx_valid ? shift_rx : 8'd0;
		result.rx_last   = rx_last;
		result.done_res  = done;
		result.status    = status;
		result.active    = (phase_d != PH_IDLE);
	end

	// Sequencer state registers, advanced once per accepted tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q          <= PH_IDLE;
			tick_count_q     <= 16'd0;
			bit_count_q      <= 4'd0;
			shift_byte_q     <= 8'd0;
			bytes_left_q     <= 8'd0;
			read_mode_q      <= 1'b0;
			length_pending_q <= 1'b0;
			scl_q            <= 1'b1;
			sda_q            <= 1'b1;
		end else if (step) begin
			phase_q          <= phase_d;
			tick_count_q     <= tick_count_d;
			bit_count_q      <= bit_count_d;
			shift_byte_q     <= shift_byte_d;
			bytes_left_q     <= bytes_left_d;
			read_mode_q      <= read_mode_d;
			length_pending_q <= length_pending_d;
			scl_q            <= scl_d;
			sda_q            <= sda_d;
		end
	end

endmodule

// ----- sv/i2cm_out_stage.sv -----
`timescale 1ns / 1ps

module i2cm_out_stage
	import i2cm_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t result_in,
	input  logic    out_ready,
	output logic    can_load,
	output logic    out_valid,
	output result_t result_out
);

	logic    valid_s2;
	result_t data_s2;

	// The slot takes a new result when empty or when its result leaves now.
	assign can_load   = !valid_s2 || out_ready;
	assign out_valid  = valid_s2;
	assign result_out = data_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (can_load) begin
			valid_s2 <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && can_load) begin
			data_s2 <= result_in;
		end
	end

endmodule

// ----- sv/i2c_master_length_framed.sv -----
`timescale 1ns / 1ps

// Length-framed I2C master sequencer, stepped by one tick per input transaction.
// Slave channel: each transaction is one timing tick; tuser carries the command
// (tick only, begin write, begin read, supply next write byte) and tdata the
// address byte, write byte, sampled SDA level and bus busy flag.
// Master channel: one result transaction per tick with the SCL and SDA drives,
// the byte request flag, a read byte with its valid flag, the done flag with
// status and the active flag; tlast marks the final byte of a read.
// Config channel: cfg_data sets the half period in ticks; write it only while
// the sequencer is idle. It is always ready.
// A tick passes through the input register, then through the sequencer into
// the output register. One tick is taken every cycle while the receiver does
// not stall; the sequencer next state is combinational from its registers.
// Reset releases both lines, returns the sequencer to idle, empties both
// registers and sets the half period to 5. When the receiver stalls, the
// output register holds its result, the input register fills and then tready
// drops; no tick is lost and the sequencer does not advance.

module i2c_master_length_framed
	import i2cm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// addr_byte [7:0], tx_byte [15:8], sda_in [16], bus_busy [17], zero [23:18]
	input  logic [23:0] s_tdata,
	// command [1:0]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// scl_out [0], sda_out [1], need_byte [2], rx_valid [3], rx_byte [11:4],
	// done_res [12], status [14:13], active [15]
	output logic [15:0] m_tdata,
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	logic        valid_s1;
	tick_t       tick_s1;
	logic        can_load;
	logic        step;
	logic [15:0] half_period_q;
	result_t     seq_result;
	result_t     out_result;

	// Half period register.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= HALF_PERIOD_RESET;
		end else if (cfg_valid) begin
			half_period_q <= cfg_data;
		end
	end

	// Input register: refills when empty or whenever its tick moves on to the sequencer.
	assign step     = valid_s1 && can_load;
	assign s_tready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			tick_s1.command   <= s_tuser;
			tick_s1.addr_byte <= s_tdata[7:0];
			tick_s1.tx_byte   <= s_tdata[15:8];
			tick_s1.sda_in    <= s_tdata[16];
			tick_s1.bus_busy  <= s_tdata[17];
		end
	end

	i2cm_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.tick        (tick_s1),
		.half_period (half_period_q),
		.result      (seq_result)
	);

	i2cm_out_stage u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (valid_s1),
		.result_in  (seq_result),
		.out_ready  (m_tready),
		.can_load   (can_load),
		.out_valid  (m_tvalid),
		.result_out (out_result)
	);

	// Pack the result onto the master channel.
	assign m_tdata = {out_result.active, out_result.status, out_result.done_res,
		out_result.rx_byte, out_result.rx_valid, out_result.need_byte,
		out_result.sda_out, out_result.scl_out};
	assign m_tlast = out_result.rx_last;

	// A finished transaction always leaves the sequencer idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && out_result.done_res) |-> !out_result.active)
		else $error("done reported while still active");

	// A nonzero status only comes with the done flag.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && out_result.status != ST_OK) |-> out_result.done_res)
		else $error("status without done");

	// The last read byte is always a valid read byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> out_result.rx_valid)
		else $error("tlast without a read byte");

	// Waiting for a write byte means a transaction is in progress.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && out_result.need_byte) |-> (out_result.active && !out_result.done_res))
		else $error("byte request outside a transaction");

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
	import i2cm_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 4;
	localparam int SQUEEZE_CYCLES = 400;
	localparam int PRINT_LIMIT    = 40;

	// Shadow copy of the sequencer registers.
	typedef struct {
		phase_t      phase;
		logic [15:0] half_ticks;
		logic [3:0]  bit_no;
		logic [7:0]  shifter;
		logic [8:0]  bytes_left;
		logic        reading;
		logic        length_due;
		logic        scl_drv;
		logic        sda_drv;
		logic [15:0] half_period;
	} seq_state_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic [1:0]  s_tuser = CMD_TICK;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic        m_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = '0;

	// Ticks waiting to be sent and the bus results they are predicted to give.
	tick_t       pending_ticks[$];
	result_t     expected_results[$];

	// seq_gen looks ahead while the stimulus is built; seq_chk follows accepted ticks.
	seq_state_t  seq_gen;
	seq_state_t  seq_chk;
	tick_t       cur_tick;
	result_t     want;

	int          ticks_made = 0;
	int          ticks_sent = 0;
	int          transfers = 0;
	int          results_seen = 0;
	int          bytes_read = 0;
	int          finished[4] = '{0, 0, 0, 0};
	int          error_count = 0;
	int          stall_cycles = 0;
	int          hold_left = 0;
	int unsigned cycle_no = 0;
	bit          squeeze_req = 1'b0;
	wire         no_idle = (cycle_no >= 1000) && (cycle_no < 3000);

	i2c_master_length_framed dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic seq_state_t idle_state();
		seq_state_t st;
		st.phase = PH_IDLE;
		st.half_ticks = '0;
		st.bit_no = '0;
		st.shifter = '0;
		st.bytes_left = '0;
		st.reading = 1'b0;
		st.length_due = 1'b0;
		st.scl_drv = 1'b1;
		st.sda_drv = 1'b1;
		st.half_period = HALF_PERIOD_RESET;
		return st;
	endfunction

	// Counts one tick of the current half; true on the tick that ends it.
	// A half period of zero behaves as one.
	function automatic bit half_over(inout seq_state_t st);
		logic [15:0] lim;
		lim = (st.half_period == 16'd0) ? 16'd1 : st.half_period;
		st.half_ticks = st.half_ticks + 16'd1;
		if (st.half_ticks >= lim) begin
			st.half_ticks = '0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void begin_tx_bit(inout seq_state_t st);
		st.phase = PH_TX_LO;
		st.scl_drv = 1'b0;
		st.sda_drv = st.shifter[7];
	endfunction

	function automatic void begin_rx_byte(inout seq_state_t st);
		st.phase = PH_RX_LO;
		st.bit_no = '0;
		st.shifter = '0;
		st.scl_drv = 1'b0;
		st.sda_drv = 1'b1;
	endfunction

	// The stop condition keeps the final status in the bit counter.
	function automatic void begin_stop(inout seq_state_t st, input logic [1:0] code);
		st.phase = PH_STOP_LO;
		st.half_ticks = '0;
		st.scl_drv = 1'b0;
		st.sda_drv = 1'b0;
		st.bit_no = {2'b00, code};
	endfunction

	// Advances the shadow sequencer by one tick and returns the bus result.
	function automatic result_t step_sequencer(inout seq_state_t st, input tick_t t);
		result_t r;
		r = '0;
		case (st.phase)
			PH_IDLE: begin
				if (t.command == CMD_WRITE || t.command == CMD_READ) begin
					if (t.bus_busy) begin
						r.done_res = 1'b1;
						r.status = ST_LOST;
					end else begin
						st.reading = (t.command == CMD_READ);
						st.shifter = t.addr_byte;
						st.bit_no = '0;
						st.bytes_left = '0;
						st.length_due = 1'b1;
						st.half_ticks = '0;
						st.scl_drv = 1'b1;
						st.sda_drv = 1'b1;
						st.phase = PH_START_HI;
					end
				end
			end
			PH_START_HI: begin
				if (half_over(st)) begin
					st.sda_drv = 1'b0;
					st.phase = PH_START_LO;
				end
			end
			PH_START_LO: begin
				if (half_over(st)) begin
					st.bit_no = '0;
					begin_tx_bit(st);
				end
			end
			// Each low half is followed by its high half in the phase encoding.
			PH_TX_LO, PH_ACK_LO, PH_RX_LO, PH_MACK_LO, PH_STOP_LO: begin
				if (half_over(st)) begin
					st.scl_drv = 1'b1;
					st.phase = phase_t'(st.phase + 4'd1);
				end
			end
			PH_TX_HI: begin
				if (half_over(st)) begin
					if (st.sda_drv && !t.sda_in) begin
						// Someone else holds SDA low: give up the bus without a stop.
						st.phase = PH_IDLE;
						st.scl_drv = 1'b1;
						st.sda_drv = 1'b1;
						r.done_res = 1'b1;
						r.status = ST_LOST;
					end else begin
						st.shifter = {st.shifter[6:0], 1'b0};
						st.bit_no = st.bit_no + 4'd1;
						if (st.bit_no >= 4'd8) begin
							st.phase = PH_ACK_LO;
							st.scl_drv = 1'b0;
							st.sda_drv = 1'b1;
						end else begin
							begin_tx_bit(st);
						end
					end
				end
			end
			PH_ACK_HI: begin
				if (half_over(st)) begin
					if (t.sda_in) begin
						begin_stop(st, ST_NACK);
					end else if (st.reading) begin
						begin_rx_byte(st);
					end else if (st.length_due || st.bytes_left != 9'd0) begin
						st.phase = PH_WAIT;
						st.scl_drv = 1'b0;
						st.sda_drv = 1'b1;
					end else begin
						begin_stop(st, ST_OK);
					end
				end
			end
			PH_WAIT: begin
				if (t.command == CMD_SUPPLY) begin
					st.shifter = t.tx_byte;
					if (st.length_due) begin
						st.bytes_left = {1'b0, t.tx_byte};
						st.length_due = 1'b0;
					end else if (st.bytes_left != 9'd0) begin
						st.bytes_left = st.bytes_left - 9'd1;
					end
					st.bit_no = '0;
					st.half_ticks = '0;
					begin_tx_bit(st);
				end
			end
			PH_RX_HI: begin
				if (half_over(st)) begin
					st.shifter = {st.shifter[6:0], t.sda_in};
					st.bit_no = st.bit_no + 4'd1;
					if (st.bit_no >= 4'd8) begin
						if (st.length_due) begin
							st.bytes_left = {1'b0, st.shifter};
							st.length_due = 1'b0;
						end else if (st.bytes_left != 9'd0) begin
							st.bytes_left = st.bytes_left - 9'd1;
						end
						r.rx_valid = 1'b1;
						r.rx_byte = st.shifter;
						r.rx_last = (st.bytes_left == 9'd0);
						st.phase = PH_MACK_LO;
						st.scl_drv = 1'b0;
						st.sda_drv = r.rx_last;
					end else begin
						st.scl_drv = 1'b0;
						st.phase = PH_RX_LO;
					end
				end
			end
			PH_MACK_HI: begin
				if (half_over(st)) begin
					if (st.bytes_left == 9'd0) begin
						begin_stop(st, ST_OK);
					end else begin
						begin_rx_byte(st);
					end
				end
			end
			PH_STOP_HI: begin
				if (half_over(st)) begin
					st.sda_drv = 1'b1;
					st.phase = PH_IDLE;
					r.done_res = 1'b1;
					r.status = st.bit_no[1:0];
				end
			end
			default: begin
				st.phase = PH_IDLE;
				st.scl_drv = 1'b1;
				st.sda_drv = 1'b1;
			end
		endcase
		r.scl_out = st.scl_drv;
		r.sda_out = st.sda_drv;
		r.need_byte = (st.phase == PH_WAIT);
		r.active = (st.phase != PH_IDLE);
		return r;
	endfunction

	function automatic tick_t noise_tick();
		tick_t t;
		t.command = CMD_TICK;
		t.addr_byte = 8'($urandom);
		t.tx_byte = 8'($urandom);
		t.sda_in = 1'($urandom);
		t.bus_busy = 1'($urandom);
		return t;
	endfunction

	task automatic push_tick(input tick_t t);
		void'(step_sequencer(seq_gen, t));
		pending_ticks.push_back(t);
		ticks_made++;
	endtask

	// Builds the ticks of one transfer, playing the slave from the look-ahead state.
	// nack_at picks which acknowledge is refused (0 is the address), lose_at which
	// released data bit sees SDA pulled low; -1 disables either.
	task automatic queue_transfer(input bit is_read, input logic [7:0] addr, input bit refuse,
			input logic [7:0] len, input int nack_at, input int lose_at);
		tick_t      t;
		int         ack_idx;
		int         one_idx;
		bit         crit;
		logic [7:0] rx_pat;
		ack_idx = -1;
		one_idx = -1;
		rx_pat = '0;
		transfers++;

		// A few ticks before the begin, some carrying a supply that the idle block ignores.
		repeat ($urandom_range(0, 3)) begin
			t = noise_tick();
			if ($urandom_range(0, 3) == 0)
				t.command = CMD_SUPPLY;
			push_tick(t);
		end
		t = noise_tick();
		t.command = is_read ? CMD_READ : CMD_WRITE;
		t.addr_byte = addr;
		t.bus_busy = refuse;
		push_tick(t);

		while (seq_gen.phase != PH_IDLE) begin
			t = noise_tick();
			crit = int'(seq_gen.half_ticks) + 1 >=
				((seq_gen.half_period == 16'd0) ? 1 : int'(seq_gen.half_period));
			// Stray begins and supplies while busy must be ignored.
			if ($urandom_range(0, 19) == 0) begin
				case ($urandom_range(0, 2))
					0: t.command = CMD_WRITE;
					1: t.command = CMD_READ;
					default: t.command = CMD_SUPPLY;
				endcase
			end
			case (seq_gen.phase)
				PH_TX_HI: begin
					if (crit && seq_gen.sda_drv) begin
						one_idx++;
						t.sda_in = (one_idx != lose_at);
					end
				end
				PH_ACK_HI: begin
					if (crit) begin
						ack_idx++;
						t.sda_in = (ack_idx == nack_at);
					end
				end
				PH_RX_HI: begin
					if (crit) begin
						if (seq_gen.bit_no == 4'd0)
							rx_pat = seq_gen.length_due ? len : 8'($urandom);
						t.sda_in = rx_pat[7 - int'(seq_gen.bit_no)];
					end
				end
				PH_WAIT: begin
					if ($urandom_range(0, 1) == 1) begin
						t.command = CMD_SUPPLY;
						if (seq_gen.length_due)
							t.tx_byte = len;
					end else begin
						case ($urandom_range(0, 3))
							0: t.command = CMD_WRITE;
							1: t.command = CMD_READ;
							default: t.command = CMD_TICK;
						endcase
					end
				end
				default: ;
			endcase
			push_tick(t);
		end
	endtask

	// Random transfers, mostly short ones, until enough ticks are queued.
	task automatic random_transfers(input int target);
		int first;
		int r;
		int len;
		int nack_at;
		int lose_at;
		first = ticks_made;
		while (ticks_made - first < target) begin
			r = $urandom_range(0, 99);
			if (r < 60)
				len = $urandom_range(0, 3);
			else if (r < 95)
				len = $urandom_range(4, 9);
			else
				len = $urandom_range(10, 24);
			nack_at = -1;
			lose_at = -1;
			if ($urandom_range(0, 99) < 12)
				nack_at = $urandom_range(0, len + 1);
			if ($urandom_range(0, 99) < 6)
				lose_at = $urandom_range(0, 15);
			queue_transfer(1'($urandom), 8'($urandom), $urandom_range(0, 99) < 5, 8'(len),
				nack_at, lose_at);
		end
	endtask

	// Waits until every tick is sent and every result is back, then lets the pipe settle.
	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_ticks.size() != 0 || s_tvalid || expected_results.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_half_period(input logic [15:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		seq_chk.half_period = value;
		seq_gen.half_period = value;
		@(negedge clk);
	endtask

	task automatic report_error(input string msg);
		if (error_count < PRINT_LIMIT)
			$display("ERROR: %s", msg);
		error_count++;
	endtask

	task automatic compare_field(input string name, input logic [7:0] got, input logic [7:0] exp_val);
		if (got !== exp_val)
			report_error($sformatf("result %0d: %s is %0h, expected %0h",
				results_seen, name, got, exp_val));
	endtask

	// Stimulus sequence: a few transfers at the reset half period, the special cases
	// at the fastest setting, then random transfers across several half periods and a refused begin at the slowest.
	initial begin
		seq_gen = idle_state();
		seq_chk = idle_state();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		queue_transfer(1'b0, 8'hA4, 1'b1, 8'd0, -1, -1);
		queue_transfer(1'b1, 8'h5B, 1'b1, 8'd0, -1, -1);
		queue_transfer(1'b0, 8'h00, 1'b0, 8'd0, -1, -1);
		wait_drained();

		// Fastest setting: directed cases and a long read, under a long receiver stall.
		set_half_period(16'd1);
		queue_transfer(1'b0, 8'hFF, 1'b0, 8'd2, -1, -1);
		queue_transfer(1'b0, 8'h3C, 1'b0, 8'd1, 0, -1);
		queue_transfer(1'b1, 8'h3D, 1'b0, 8'd1, 0, -1);
		queue_transfer(1'b0, 8'h42, 1'b0, 8'd1, 2, -1);
		queue_transfer(1'b0, 8'h42, 1'b0, 8'd3, 1, -1);
		queue_transfer(1'b1, 8'h91, 1'b0, 8'd0, -1, -1);
		queue_transfer(1'b1, 8'h91, 1'b0, 8'd2, -1, -1);
		queue_transfer(1'b0, 8'h80, 1'b0, 8'd0, -1, 0);
		queue_transfer(1'b0, 8'h01, 1'b0, 8'd1, -1, 2);
		queue_transfer(1'b1, 8'hFE, 1'b0, 8'd0, -1, 6);
		queue_transfer(1'b0, 8'h66, 1'b0, 8'd255, 3, -1);
		queue_transfer(1'b1, 8'hC3, 1'b0, 8'd8, -1, -1);
		random_transfers(50);
		squeeze_req = 1'b1;
		wait_drained();

		set_half_period(16'd0);
		random_transfers(50);
		wait_drained();

		set_half_period(16'd3);
		random_transfers(50);
		wait_drained();

		// Slowest setting: a refused begin.
		set_half_period(16'hFFFF);
		queue_transfer(1'b1, 8'h17, 1'b1, 8'd0, -1, -1);
		wait_drained();

		set_half_period(16'd2);
		random_transfers(50);
		wait_drained();

		$display("Sent %0d ticks in %0d transfers over six half periods; %0d bytes read back.",
			ticks_sent, transfers, bytes_read);
		$display("Transfers ended: %0d ok, %0d lost or refused, %0d nacked; %0d mismatches.",
			finished[ST_OK], finished[ST_LOST], finished[ST_NACK], error_count);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Tick driver: predicts each accepted tick and offers the next one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= CMD_TICK;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_results.push_back(step_sequencer(seq_chk, cur_tick));
				ticks_sent++;
			end
			if (!s_tvalid || s_tready) begin
				if (pending_ticks.size() != 0 && (no_idle || $urandom_range(0, 99) >= 7)) begin
					cur_tick = pending_ticks.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {6'd0, cur_tick.bus_busy, cur_tick.sda_in, cur_tick.tx_byte,
						cur_tick.addr_byte};
					s_tuser <= cur_tick.command;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result receiver: random stalls, plus one long hold-off on request.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_left = 0;
		end else if (hold_left != 0) begin
			hold_left = hold_left - 1;
			m_tready <= 1'b0;
		end else if (squeeze_req) begin
			squeeze_req = 1'b0;
			hold_left = SQUEEZE_CYCLES;
			m_tready <= 1'b0;
		end else begin
			m_tready <= no_idle || ($urandom_range(0, 99) >= 7);
		end
	end

	// Result checker: each transaction is compared with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				report_error($sformatf("result %0d arrived with no tick outstanding",
					results_seen));
			end else begin
				want = expected_results.pop_front();
				compare_field("scl_out", 8'(m_tdata[0]), 8'(want.scl_out));
				compare_field("sda_out", 8'(m_tdata[1]), 8'(want.sda_out));
				compare_field("need_byte", 8'(m_tdata[2]), 8'(want.need_byte));
				compare_field("rx_valid", 8'(m_tdata[3]), 8'(want.rx_valid));
				compare_field("rx_byte", m_tdata[11:4], want.rx_byte);
				compare_field("rx_last", 8'(m_tlast), 8'(want.rx_last));
				compare_field("done_res", 8'(m_tdata[12]), 8'(want.done_res));
				compare_field("status", 8'(m_tdata[14:13]), 8'(want.status));
				compare_field("active", 8'(m_tdata[15]), 8'(want.active));
			end
			results_seen++;
			if (m_tdata[12] === 1'b1)
				finished[m_tdata[14:13]]++;
			if (m_tdata[3] === 1'b1)
				bytes_read++;
		end
	end

	// Watchdog on cycles with no transaction on any channel.
	always @(posedge clk) begin
		cycle_no <= cycle_no + 1;
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("Timeout: no transaction for %0d cycles.", stall_cycles);
			$display("DONE: errors detected");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

endmodule
